/* rtl/core/rgb565_box_downsample_2x2_core_macros.svh */
// Assertion helpers for the downsample core. They sample on clk_i and are
// disabled while rst_ni is low.
`ifndef RGB565_BOX_DOWNSAMPLE_2X2_CORE_MACROS_SVH
`define RGB565_BOX_DOWNSAMPLE_2X2_CORE_MACROS_SVH

`define RGBDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define RGBDS_NEVER(label, cond, msg) \
  `RGBDS_ASSERT(label, !(cond), msg)

`endif

/* rtl/core/rgbds_pkg.sv */
`timescale 1ns / 1ps

package rgbds_pkg;

  localparam int unsigned SOURCE_WIDTH = 640;
  localparam int unsigned OUT_WIDTH    = 320;
  localparam int unsigned OUT_HEIGHT   = 240;

  localparam int unsigned CNT_W  = 10;
  localparam int unsigned HALF_W = CNT_W - 1;
  localparam int unsigned OX_W   = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
  localparam int unsigned SUM_W  = 19;
  localparam int unsigned PIX_W  = 16;

  localparam logic [CNT_W-1:0] ROW_MAX = '1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  typedef enum logic {
    OP_WRITE,
    OP_OUTPUT
  } op_kind_e;

  typedef struct packed {
    op_kind_e        kind;
    logic [OX_W-1:0] addr;
    logic [SUM_W-1:0] sums;
    logic            last;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Per-channel sum of two RGB565 pixels, packed as red 6, green 7, blue 6 bits.
  function automatic logic [SUM_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    logic [5:0] r;
    logic [6:0] g;
    logic [5:0] bl;
    r  = {1'b0, a[15:11]} + {1'b0, b[15:11]};
    g  = {1'b0, a[10:5]} + {1'b0, b[10:5]};
    bl = {1'b0, a[4:0]} + {1'b0, b[4:0]};
    return {r, g, bl};
  endfunction

endpackage

/* rtl/core/rgbds_if.sv */
`timescale 1ns / 1ps

interface rgbds_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel;
  logic        first_of_frame;

  modport source (output valid, output pixel, output first_of_frame, input ready);
  modport sink (input valid, input pixel, input first_of_frame, output ready);
endinterface

interface rgbds_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_pixel;
  logic        last_of_frame;

  modport source (output valid, output out_pixel, output last_of_frame, input ready);
  modport sink (input valid, input out_pixel, input last_of_frame, output ready);
endinterface

/* rtl/core/rgbds_ram.sv */
`timescale 1ns / 1ps

module rgbds_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/rgbds_front.sv */
`timescale 1ns / 1ps

module rgbds_front import rgbds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rgbds_in_if.sink    in_i,
  input  queue_stat_t stat_i,
  output logic        push_o,
  output op_t         push_data_o
);

  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [CNT_W-1:0] col_eff, row_eff;
  logic [PIX_W-1:0] held_q;
  logic [CNT_W:0]   next_col;
  logic             accept, in_grid;

  assign in_i.ready = !stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    col_eff  = in_i.first_of_frame ? '0 : col_q;
    row_eff  = in_i.first_of_frame ? '0 : row_q;
    in_grid  = col_eff[0]
            && ({1'b0, col_eff} < (CNT_W+1)'(2 * OUT_WIDTH))
            && ({1'b0, row_eff} < (CNT_W+1)'(2 * OUT_HEIGHT));
    next_col = {1'b0, col_eff} + (CNT_W+1)'(1);
    if (next_col >= (CNT_W+1)'(SOURCE_WIDTH)) begin
      col_d = '0;
      row_d = (row_eff < ROW_MAX) ? row_eff + CNT_W'(1) : ROW_MAX;
    end else begin
      col_d = next_col[CNT_W-1:0];
      row_d = row_eff;
    end
  end

  always_comb begin
    push_o           = accept && in_grid;
    push_data_o.kind = row_eff[0] ? OP_OUTPUT : OP_WRITE;
    push_data_o.addr = col_eff[OX_W:1];
    push_data_o.sums = pair_sum(held_q, in_i.pixel);
    push_data_o.last = (col_eff[CNT_W-1:1] == HALF_W'(OUT_WIDTH - 1))
                    && (row_eff[CNT_W-1:1] == HALF_W'(OUT_HEIGHT - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      if (!col_eff[0]) begin
        held_q <= in_i.pixel;
      end
    end
  end

endmodule

/* rtl/core/rgbds_queue.sv */
`timescale 1ns / 1ps

module rgbds_queue import rgbds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  op_t         push_data_i,
  input  logic        pop_i,
  output op_t         head_o,
  output queue_stat_t stat_o
);

  op_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

/* rtl/core/rgbds_back.sv */
`timescale 1ns / 1ps

module rgbds_back import rgbds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_stat_t stat_i,
  input  op_t         head_i,
  output logic        pop_o,
  rgbds_out_if.source out_o
);

  logic             rd_fire, wr_fire, b_moves;
  logic             b_valid_q, out_valid_q;
  logic [SUM_W-1:0] b_sums_q, up_sums;
  logic             b_last_q, out_last_q;
  logic [PIX_W-1:0] out_pixel_q, avg_pixel;
  logic [6:0]       r_tot, b_tot;
  logic [7:0]       g_tot;

  assign b_moves = b_valid_q && (!out_valid_q || out_o.ready);
  assign wr_fire = !stat_i.empty && (head_i.kind == OP_WRITE);
  assign rd_fire = !stat_i.empty && (head_i.kind == OP_OUTPUT) && (!b_valid_q || b_moves);
  assign pop_o   = wr_fire || rd_fire;

  rgbds_ram #(
    .Width (SUM_W),
    .Depth (OUT_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr_fire),
    .waddr_i (head_i.addr),
    .wdata_i (head_i.sums),
    .re_i    (rd_fire),
    .raddr_i (head_i.addr),
    .rdata_o (up_sums)
  );

  always_comb begin
    r_tot     = {1'b0, b_sums_q[18:13]} + {1'b0, up_sums[18:13]};
    g_tot     = {1'b0, b_sums_q[12:6]} + {1'b0, up_sums[12:6]};
    b_tot     = {1'b0, b_sums_q[5:0]} + {1'b0, up_sums[5:0]};
    avg_pixel = {r_tot[6:2], g_tot[7:2], b_tot[6:2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rd_fire) begin
        b_valid_q <= 1'b1;
      end else if (b_moves) begin
        b_valid_q <= 1'b0;
      end
      if (b_moves) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      b_sums_q <= head_i.sums;
      b_last_q <= head_i.last;
    end
    if (b_moves) begin
      out_pixel_q <= avg_pixel;
      out_last_q  <= b_last_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_pixel     = out_pixel_q;
  assign out_o.last_of_frame = out_last_q;

endmodule

/* rtl/core/rgb565_box_downsample_2x2_core.sv */
`timescale 1ns / 1ps
// Channel  Direction  Word
// in_i     sink       pixel[15:0] (RGB565), first_of_frame
// out_o    source     out_pixel[15:0] (RGB565), last_of_frame
//
// One source pixel is taken every cycle while the four-entry queue has room.
// A result passes from the queue through the b stage register into the output register.
// The line memory is read or written at most once per cycle, from the queue head.
// Reset clears counters and handshake state; the line memory needs no clearing.
// A stalled output backs up through the queue and then drops in_i.ready.

`include "rgb565_box_downsample_2x2_core_macros.svh"

module rgb565_box_downsample_2x2_core import rgbds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rgbds_in_if.sink    in_i,
  rgbds_out_if.source out_o
);

  logic        q_push, q_pop;
  op_t         q_push_data, q_head;
  queue_stat_t q_stat;

  rgbds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .stat_i      (q_stat),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  rgbds_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .stat_o      (q_stat)
  );

  rgbds_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (q_stat),
    .head_i (q_head),
    .pop_o  (q_pop),
    .out_o  (out_o)
  );

  `RGBDS_NEVER(a_pop_empty, q_pop && q_stat.empty, "pop from empty queue")
  `RGBDS_NEVER(a_push_full, q_push && q_stat.full, "push into full queue")
  `RGBDS_ASSERT(a_push_fills, (q_push && q_stat.empty) |=> !q_stat.empty, "push lost")

endmodule

/* tb/rgb565_box_downsample_2x2_core_tb.sv */
`timescale 1ns / 1ps

module rgb565_box_downsample_2x2_core_tb;
  import rgbds_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned PHASE_A_WORDS = 230;
  localparam int unsigned PHASE_B_WORDS = 230;
  localparam int unsigned PHASE_C_WORDS = 240;
  localparam int unsigned MAX_REPORTS   = 40;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned DIR_ROWS      = 11;

  typedef struct packed {
    logic [15:0] pix;
    logic        last;
  } block_avg_t;

  typedef struct packed {
    logic [15:0] pix;
    logic        fof;
    logic        rnd;
    logic [10:0] reps;
    logic        typed;
    logic [15:0] want;
  } dir_row_t;

  // Uniform pairs of the first row sit above uniform pairs of the second, so
  // the averages of those blocks are plain to see.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{16'hFFFF, 1'b1, 1'b0, 11'd2,   1'b0, 16'h0000},
    '{16'hF800, 1'b0, 1'b0, 11'd2,   1'b0, 16'h0000},
    '{16'h07E0, 1'b0, 1'b0, 11'd2,   1'b0, 16'h0000},
    '{16'h001F, 1'b0, 1'b0, 11'd2,   1'b0, 16'h0000},
    '{16'h0000, 1'b0, 1'b0, 11'd2,   1'b0, 16'h0000},
    '{16'h0000, 1'b0, 1'b1, 11'd630, 1'b0, 16'h0000},
    '{16'hFFFF, 1'b0, 1'b0, 11'd2,   1'b1, 16'hFFFF},
    '{16'hF800, 1'b0, 1'b0, 11'd2,   1'b1, 16'hF800},
    '{16'h07E0, 1'b0, 1'b0, 11'd2,   1'b1, 16'h07E0},
    '{16'h001F, 1'b0, 1'b0, 11'd2,   1'b1, 16'h001F},
    '{16'hFFFF, 1'b0, 1'b0, 11'd2,   1'b1, 16'h7BEF}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rgbds_in_if  in_if ();
  rgbds_out_if out_if ();

  rgb565_box_downsample_2x2_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [CNT_W-1:0] col_q;
  logic [CNT_W-1:0] row_q;
  logic [15:0]      held_q;
  logic [SUM_W-1:0] upper_sums [OUT_WIDTH];

  block_avg_t  awaited_avgs [$];
  int unsigned fault_count;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit average_block(input logic [15:0] px, input logic fof,
                                       output block_avg_t avg);
    logic [CNT_W-1:0] c;
    logic [CNT_W-1:0] r;
    logic [SUM_W-1:0] s;
    logic [SUM_W-1:0] u;
    logic [6:0]       rs;
    logic [7:0]       gs;
    logic [6:0]       bs;
    bit               hit;
    hit = 1'b0;
    avg = '0;
    c = fof ? '0 : col_q;
    r = fof ? '0 : row_q;
    if (!c[0]) begin
      held_q = px;
    end else if (c < 2 * OUT_WIDTH && r < 2 * OUT_HEIGHT) begin
      s[18:13] = {1'b0, held_q[15:11]} + {1'b0, px[15:11]};
      s[12:6]  = {1'b0, held_q[10:5]} + {1'b0, px[10:5]};
      s[5:0]   = {1'b0, held_q[4:0]} + {1'b0, px[4:0]};
      if (!r[0]) begin
        upper_sums[c[CNT_W-1:1]] = s;
      end else begin
        u  = upper_sums[c[CNT_W-1:1]];
        rs = {1'b0, s[18:13]} + {1'b0, u[18:13]};
        gs = {1'b0, s[12:6]} + {1'b0, u[12:6]};
        bs = {1'b0, s[5:0]} + {1'b0, u[5:0]};
        avg.pix  = {rs[6:2], gs[7:2], bs[6:2]};
        avg.last = (c[CNT_W-1:1] == OUT_WIDTH - 1) && (r[CNT_W-1:1] == OUT_HEIGHT - 1);
        hit = 1'b1;
      end
    end
    if (int'(c) + 1 >= SOURCE_WIDTH) begin
      col_q = '0;
      row_q = (r == ROW_MAX) ? r : r + 1'b1;
    end else begin
      col_q = c + 1'b1;
      row_q = r;
    end
    return hit;
  endfunction

  function automatic void flag_mismatch(input string field, input logic [15:0] want,
                                        input logic [15:0] seen);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $error("%s: expected %h, got %h", field, want, seen);
    end
  endfunction

  task automatic send_word(input logic [15:0] px, input logic fof, input logic typed,
                           input logic [15:0] want);
    block_avg_t avg;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.pixel          <= px;
    in_if.first_of_frame <= fof;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (average_block(px, fof, avg)) begin
      if (typed) begin
        avg.pix  = want;
        avg.last = 1'b0;
      end
      awaited_avgs.push_back(avg);
    end
  endtask

  task automatic send_random(input logic fof);
    logic [15:0] px;
    px = 16'($urandom);
    if ($urandom_range(7) == 0) begin
      px = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end
    send_word(px, fof, 1'b0, 16'h0000);
  endtask

  // The phases continue the directed frame; a rare word starts a new one.
  task automatic random_phase(input int unsigned src_pct, input int unsigned sink_pct,
                              input int unsigned words);
    int unsigned sent;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (sent = 0; sent < words; sent++) begin
      send_random($urandom_range(3999) == 0);
    end
  endtask

  always @(posedge clk_i) begin : drain_outputs
    block_avg_t wanted;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (awaited_avgs.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $error("unexpected word: out_pixel %h, last_of_frame %b",
                   out_if.out_pixel, out_if.last_of_frame);
          end
        end else begin
          wanted = awaited_avgs.pop_front();
          if (out_if.out_pixel !== wanted.pix) begin
            flag_mismatch("out_pixel", wanted.pix, out_if.out_pixel);
          end
          if (out_if.last_of_frame !== wanted.last) begin
            flag_mismatch("last_of_frame", 16'(wanted.last), 16'(out_if.last_of_frame));
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rgb565_box_downsample_2x2_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    dir_row_t    row_e;
    int unsigned k;
    int unsigned n;
    in_if.valid          = 1'b0;
    in_if.pixel          = 16'h0000;
    in_if.first_of_frame = 1'b0;
    out_if.ready         = 1'b0;
    col_q                = '0;
    row_q                = '0;
    held_q               = '0;
    fault_count          = 0;
    cycle_count          = 0;
    src_idle_pct         = 28;
    sink_idle_pct        = 82;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < DIR_ROWS; k++) begin
      row_e = dir_rows[k];
      for (n = 0; n < row_e.reps; n++) begin
        send_word(row_e.rnd ? 16'($urandom) : row_e.pix, row_e.fof && n == 0,
                  row_e.typed, row_e.want);
      end
    end

    random_phase(28, 82, PHASE_A_WORDS);
    random_phase(82, 28, PHASE_B_WORDS);
    random_phase(0, 0, PHASE_C_WORDS);

    in_if.valid <= 1'b0;
    while (awaited_avgs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("rgb565_box_downsample_2x2_core_tb OK");
    end else begin
      $display("rgb565_box_downsample_2x2_core_tb NOT OK");
    end
    $finish;
  end

endmodule

/* rgb565_box_downsample_2x2_core.f */
+incdir+rtl/core
rtl/core/rgbds_pkg.sv
rtl/core/rgbds_if.sv
rtl/core/rgbds_ram.sv
rtl/core/rgbds_front.sv
rtl/core/rgbds_queue.sv
rtl/core/rgbds_back.sv
rtl/core/rgb565_box_downsample_2x2_core.sv
tb/rgb565_box_downsample_2x2_core_tb.sv
